// ----- sv/iirl_pkg.sv -----
// ============================================================================
// iirl_pkg: shared types and constants for the indexed insert/remove list
// Holds the command and status codes, the cell shift operations and the
// default sizes that the top level hands down to its submodules.
// ============================================================================
package iirl_pkg;

    // Default number of list entries and width of one stored value.
    localparam int DEPTH_DEF      = 16;
    localparam int VALUE_BITS_DEF = 64;

    // Widths of the fixed interface fields.
    localparam int CMD_W    = 3;
    localparam int POS_W    = 8;
    localparam int ITEM_W   = 64;
    localparam int STATUS_W = 2;

    // Command codes carried on the command port.
    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT  = 3'd0,
        CMD_REMOVE  = 3'd1,
        CMD_PUSH    = 3'd2,
        CMD_POP     = 3'd3,
        CMD_UNSHIFT = 3'd4,
        CMD_SHIFT   = 3'd5
    } t_cmd;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_NIL  = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    // What every cell of the chain does each cycle.
    typedef enum logic [1:0] {
        SH_HOLD   = 2'd0,
        SH_INSERT = 2'd1,
        SH_REMOVE = 2'd2
    } t_shift;

endpackage

// ----- sv/iirl_ctrl.sv -----
// ============================================================================
// iirl_ctrl: command decoder for the indexed insert/remove list
// Turns one command word and the current length into the shift operation
// and target index broadcast to the cells, the status and the next length.
// ============================================================================
module iirl_ctrl #(
    parameter int DEPTH = iirl_pkg::DEPTH_DEF,
    parameter int CNT_W = $clog2(DEPTH + 1),
    parameter int IDX_W = (CNT_W > iirl_pkg::POS_W) ? CNT_W : iirl_pkg::POS_W
) (
    input  logic [iirl_pkg::CMD_W-1:0] i_command,
    input  logic [iirl_pkg::POS_W-1:0] i_position,
    input  logic [CNT_W-1:0]           i_count,
    output iirl_pkg::t_shift           o_op,
    output logic [IDX_W-1:0]           o_at,
    output iirl_pkg::t_status          o_status,
    output logic [CNT_W-1:0]           o_next_count
);

    logic [IDX_W-1:0] pos_w;
    logic [IDX_W-1:0] cnt_w;
    logic             full;
    logic             empty;

    assign pos_w = IDX_W'(i_position);
    assign cnt_w = IDX_W'(i_count);
    assign full  = (i_count == CNT_W'(DEPTH));
    assign empty = (i_count == '0);

    always_comb begin
        o_op         = iirl_pkg::SH_HOLD;
        o_at         = '0;
        o_status     = iirl_pkg::ST_OK;
        o_next_count = i_count;
        case (iirl_pkg::t_cmd'(i_command))
            iirl_pkg::CMD_INSERT, iirl_pkg::CMD_PUSH, iirl_pkg::CMD_UNSHIFT: begin
                if (full) begin
                    o_status = iirl_pkg::ST_FULL;
                end else begin
                    o_op         = iirl_pkg::SH_INSERT;
                    o_next_count = i_count + CNT_W'(1);
                    if (iirl_pkg::t_cmd'(i_command) == iirl_pkg::CMD_PUSH) begin
                        o_at = cnt_w;
                    end else if (iirl_pkg::t_cmd'(i_command) == iirl_pkg::CMD_UNSHIFT) begin
                        o_at = '0;
                    end else begin
                        // An index past the end appends.
                        o_at = (pos_w > cnt_w) ? cnt_w : pos_w;
                    end
                end
            end
            iirl_pkg::CMD_REMOVE: begin
                if (pos_w >= cnt_w) begin
                    o_status = iirl_pkg::ST_NIL;
                end else begin
                    o_op         = iirl_pkg::SH_REMOVE;
                    o_at         = pos_w;
                    o_next_count = i_count - CNT_W'(1);
                end
            end
            iirl_pkg::CMD_POP, iirl_pkg::CMD_SHIFT: begin
                if (empty) begin
                    o_status = iirl_pkg::ST_NIL;
                end else begin
                    o_op         = iirl_pkg::SH_REMOVE;
                    o_next_count = i_count - CNT_W'(1);
                    o_at = (iirl_pkg::t_cmd'(i_command) == iirl_pkg::CMD_POP)
                         ? (cnt_w - IDX_W'(1)) : '0;
                end
            end
            default: begin
                o_status = iirl_pkg::ST_NIL;
            end
        endcase
    end

endmodule

// ----- sv/iirl_cell.sv -----
// ============================================================================
// iirl_cell: one entry of the shift-register list
// Holds one value and, each cycle, keeps it, takes the new value, or takes
// the value of its lower or upper neighbor. Also drives its value onto the
// read bus when it is the entry being removed.
// ============================================================================
module iirl_cell #(
    parameter int IDX        = 0,
    parameter int IDX_W      = 8,
    parameter int VALUE_BITS = iirl_pkg::VALUE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  iirl_pkg::t_shift      i_op,
    input  logic [IDX_W-1:0]      i_at,
    input  logic [VALUE_BITS-1:0] i_new_val,
    input  logic [VALUE_BITS-1:0] i_lower_val,
    input  logic [VALUE_BITS-1:0] i_upper_val,
    output logic [VALUE_BITS-1:0] o_val,
    output logic [VALUE_BITS-1:0] o_rd_val
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic [VALUE_BITS-1:0] r_val;
    logic [VALUE_BITS-1:0] n_val;
    logic                  hit;

    assign hit = (i_at == MY_IDX);

    always_comb begin
        n_val = r_val;
        case (i_op)
            iirl_pkg::SH_INSERT: begin
                if (hit) begin
                    n_val = i_new_val;
                end else if (MY_IDX > i_at) begin
                    n_val = i_lower_val;
                end
            end
            iirl_pkg::SH_REMOVE: begin
                if (MY_IDX >= i_at) begin
                    n_val = i_upper_val;
                end
            end
            default: begin
                n_val = r_val;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_val <= n_val;
        end
    end

    assign o_val    = r_val;
    assign o_rd_val = (hit && (i_op == iirl_pkg::SH_REMOVE)) ? r_val : '0;

endmodule

// ----- sv/indexed_insert_remove_list.sv -----
// ============================================================================
// indexed_insert_remove_list: bounded ordered list in a shift-register chain
// Insert, remove, push, pop, unshift and shift on a list of up to DEPTH
// values, one command word per clock cycle.
// ============================================================================
// The block takes one command word in every clock cycle: busy never rises,
// so start may stay high back to back. Every entry sits in its own cell, and
// all cells move at once, so insert and remove at any index finish at the
// clock edge that accepts the word. The result word appears on the output
// ports in the following cycle with o_done high for exactly that one cycle;
// the receiver cannot stall it and must take it then. o_new_length is the
// list length after the command. A failed command (insert into a full list,
// remove at or past the end, pop or shift on an empty list, an unknown
// command) leaves the list unchanged and returns a zero removed value.
// The path from start to the cell registers is one index compare per cell;
// the removed value is read through a one-hot AND-OR across the cells.
// ============================================================================
module indexed_insert_remove_list #(
    parameter int DEPTH      = iirl_pkg::DEPTH_DEF,
    parameter int VALUE_BITS = iirl_pkg::VALUE_BITS_DEF,
    parameter int CNT_W      = $clog2(DEPTH + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [iirl_pkg::CMD_W-1:0]    i_command,
    input  logic [iirl_pkg::POS_W-1:0]    i_position,
    input  logic [iirl_pkg::ITEM_W-1:0]   i_item_value,
    output logic                          o_done,
    output logic [iirl_pkg::ITEM_W-1:0]   o_removed_value,
    output logic [iirl_pkg::STATUS_W-1:0] o_status,
    output logic [CNT_W-1:0]              o_new_length
);

    localparam int IDX_W = (CNT_W > iirl_pkg::POS_W) ? CNT_W : iirl_pkg::POS_W;

    logic                  accept;
    iirl_pkg::t_shift      op;
    iirl_pkg::t_shift      cell_op;
    logic [IDX_W-1:0]      at;
    iirl_pkg::t_status     status;
    logic [CNT_W-1:0]      n_count;
    logic [VALUE_BITS-1:0] new_val;
    logic [VALUE_BITS-1:0] cell_val [DEPTH];
    logic [VALUE_BITS-1:0] cell_rd  [DEPTH];
    logic [VALUE_BITS-1:0] rd_val;

    logic [CNT_W-1:0]          r_count;
    logic                      r_done;
    logic [VALUE_BITS-1:0]     r_removed;
    iirl_pkg::t_status         r_status;

    // Every word is taken at once; there is nothing to wait for.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Only the low VALUE_BITS bits of the item are stored.
    assign new_val = i_item_value[VALUE_BITS-1:0];

    iirl_ctrl #(
        .DEPTH (DEPTH),
        .CNT_W (CNT_W),
        .IDX_W (IDX_W)
    ) u_ctrl (
        .i_command    (i_command),
        .i_position   (i_position),
        .i_count      (r_count),
        .o_op         (op),
        .o_at         (at),
        .o_status     (status),
        .o_next_count (n_count)
    );

    // Without an accepted word the cells simply hold.
    assign cell_op = accept ? op : iirl_pkg::SH_HOLD;

    // The chain: each cell sees its lower and upper neighbor. The ends see
    // zero, which only ever lands in entries at or past the length.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [VALUE_BITS-1:0] lower_val;
        logic [VALUE_BITS-1:0] upper_val;

        if (g == 0) begin : g_first
            assign lower_val = '0;
        end else begin : g_mid_lo
            assign lower_val = cell_val[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign upper_val = '0;
        end else begin : g_mid_hi
            assign upper_val = cell_val[g+1];
        end

        iirl_cell #(
            .IDX        (g),
            .IDX_W      (IDX_W),
            .VALUE_BITS (VALUE_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_en        (accept),
            .i_op        (cell_op),
            .i_at        (at),
            .i_new_val   (new_val),
            .i_lower_val (lower_val),
            .i_upper_val (upper_val),
            .o_val       (cell_val[g]),
            .o_rd_val    (cell_rd[g])
        );
    end

    // At most one cell drives a nonzero read value, so an OR selects it.
    always_comb begin
        rd_val = '0;
        for (int k = 0; k < DEPTH; k++) begin
            rd_val = rd_val | cell_rd[k];
        end
    end

    // Length and result registers. The result registers load with each
    // accepted word and o_done marks the single cycle they are valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= accept;
            if (accept) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_removed <= rd_val;
            r_status  <= status;
        end
    end

    assign o_done          = r_done;
    assign o_removed_value = iirl_pkg::ITEM_W'(r_removed);
    assign o_status        = r_status;
    assign o_new_length    = r_count;

    // A result follows every accepted word in the next cycle, and only then.
    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_done)
        else $error("result strobe missing after an accepted word");

    a_no_spurious_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |=> !o_done)
        else $error("result strobe without an accepted word");

    // The length never exceeds the capacity.
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("list length beyond capacity");

    // A failed command returns no value.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (r_status != iirl_pkg::ST_OK)) |-> (o_removed_value == '0))
        else $error("failed command returned a value");

    // A full rejection only happens at capacity.
    a_full_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (r_status == iirl_pkg::ST_FULL)) |-> (o_new_length == CNT_W'(DEPTH)))
        else $error("full status below capacity");

endmodule

// ----- tb/indexed_insert_remove_list_tb.sv -----
// ============================================================================
// indexed_insert_remove_list_tb: self-checking bench for the insert/remove list
// Drives command words through the start/busy handshake, keeps its own copy
// of the list, and checks every strobed result word field by field.
// ============================================================================
module indexed_insert_remove_list_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH       = iirl_pkg::DEPTH_DEF;
    localparam int LEN_W       = $clog2(DEPTH + 1);
    localparam int RANDOM_WORDS = 1930;
    localparam int CYCLE_LIMIT = 400_000;
    localparam int MAX_REPORTS = 10;

    // The two command codes that the block does not define. They must come
    // back as nil with the list untouched.
    localparam logic [iirl_pkg::CMD_W-1:0] CMD_UNDEF_6 = 3'd6;
    localparam logic [iirl_pkg::CMD_W-1:0] CMD_UNDEF_7 = 3'd7;

    localparam logic [iirl_pkg::ITEM_W-1:0] ALL_ONES = {iirl_pkg::ITEM_W{1'b1}};

    // One result word as the block reports it.
    typedef struct packed {
        logic [iirl_pkg::ITEM_W-1:0] removed;
        iirl_pkg::t_status           status;
        logic [LEN_W-1:0]            length;
    } t_list_result;

    // One row of the directed table. A row with a typed result is checked
    // against that value; the others are checked against the list shadow.
    typedef struct {
        logic [iirl_pkg::CMD_W-1:0]  cmd;
        logic [iirl_pkg::POS_W-1:0]  pos;
        logic [iirl_pkg::ITEM_W-1:0] val;
        int unsigned                 reps;
        bit                          typed;
        t_list_result                res;
    } t_dir_row;

    localparam int NUM_DIR = 20;

    logic                              i_clk;
    logic                              i_rst_n      = 1'b0;
    logic                              start        = 1'b0;
    logic                              busy;
    logic [iirl_pkg::CMD_W-1:0]        i_command    = '0;
    logic [iirl_pkg::POS_W-1:0]        i_position   = '0;
    logic [iirl_pkg::ITEM_W-1:0]       i_item_value = '0;
    logic                              o_done;
    logic [iirl_pkg::ITEM_W-1:0]       o_removed_value;
    logic [iirl_pkg::STATUS_W-1:0]     o_status;
    logic [LEN_W-1:0]                  o_new_length;

    // Travel with the command word, so the checker knows at acceptance
    // whether a typed result replaces the shadow's answer.
    bit                                word_typed   = 1'b0;
    t_list_result                      word_expect  = '0;

    // Shadow of the list contents, head at index 0.
    logic [iirl_pkg::ITEM_W-1:0]       list_shadow [$];
    // Result words accepted but not yet seen on the outputs, oldest first.
    t_list_result                      pending_results [$];

    int unsigned           error_count  = 0;
    int unsigned           cycle_count  = 0;
    int unsigned           adds_seen    = 0;
    int unsigned           takes_seen   = 0;
    int unsigned           undef_seen   = 0;
    int unsigned           nil_seen     = 0;
    int unsigned           full_seen    = 0;
    int unsigned           peak_length  = 0;
    bit                    no_idle      = 1'b0;

    t_dir_row              dir_rows [NUM_DIR];

    indexed_insert_remove_list uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_command      (i_command),
        .i_position     (i_position),
        .i_item_value   (i_item_value),
        .o_done         (o_done),
        .o_removed_value(o_removed_value),
        .o_status       (o_status),
        .o_new_length   (o_new_length)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // List shadow. It applies one command word to its copy of the list and
    // returns the result word the block must report for it. A failed command
    // leaves the shadow as it was and reports a zero removed value.
    // ------------------------------------------------------------------------
    function automatic t_list_result apply_word(logic [iirl_pkg::CMD_W-1:0] cmd,
                                                logic [iirl_pkg::POS_W-1:0] pos,
                                                logic [iirl_pkg::ITEM_W-1:0] val);
        t_list_result res;
        int unsigned  len;
        int unsigned  at;
        int unsigned  pos_u;
        bit           is_add;
        bit           is_take;

        res     = '0;
        res.status = iirl_pkg::ST_OK;
        len     = list_shadow.size();
        pos_u   = 32'(pos);
        is_add  = 1'b0;
        is_take = 1'b0;
        at      = 0;

        case (cmd)
            iirl_pkg::CMD_INSERT: begin
                is_add = 1'b1;
                // An index past the end is clamped, which appends.
                at = (pos_u > len) ? len : pos_u;
            end
            iirl_pkg::CMD_PUSH: begin
                is_add = 1'b1;
                at = len;
            end
            iirl_pkg::CMD_UNSHIFT: begin
                is_add = 1'b1;
                at = 0;
            end
            iirl_pkg::CMD_REMOVE: begin
                is_take = 1'b1;
                at = pos_u;
            end
            iirl_pkg::CMD_POP: begin
                is_take = 1'b1;
                // On an empty list this index is past the end, hence nil.
                at = (len == 0) ? 0 : len - 1;
            end
            iirl_pkg::CMD_SHIFT: begin
                is_take = 1'b1;
                at = 0;
            end
            default: begin
                res.status = iirl_pkg::ST_NIL;
                undef_seen++;
            end
        endcase

        if (is_add) begin
            adds_seen++;
            if (len >= DEPTH) begin
                res.status = iirl_pkg::ST_FULL;
            end else begin
                list_shadow.insert(at, val);
            end
        end
        if (is_take) begin
            takes_seen++;
            if (at >= len) begin
                res.status = iirl_pkg::ST_NIL;
            end else begin
                res.removed = list_shadow[at];
                list_shadow.delete(at);
            end
        end

        if (res.status == iirl_pkg::ST_NIL) nil_seen++;
        if (res.status == iirl_pkg::ST_FULL) full_seen++;
        if (list_shadow.size() > peak_length) peak_length = list_shadow.size();
        res.length = LEN_W'(list_shadow.size());
        return res;
    endfunction

    task automatic note_mismatch(string what, logic [iirl_pkg::ITEM_W-1:0] want,
                                 logic [iirl_pkg::ITEM_W-1:0] got);
        error_count++;
        if (error_count <= MAX_REPORTS) begin
            $display("[%0t] mismatch in %s: expected %h, got %h", $realtime, what,
                     want, got);
        end
    endtask

    // ------------------------------------------------------------------------
    // Checker. Everything is sampled at the rising edge, so it sees the values
    // that held during the cycle the edge ends. A strobed result word is
    // matched against the oldest pending one; a command word accepted at the
    // same edge adds its own expectation behind it.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : check_results
        t_list_result got;
        t_list_result want;
        t_list_result pred;

        if (i_rst_n) begin
            if (o_done) begin
                got.removed = o_removed_value;
                got.status  = iirl_pkg::t_status'(o_status);
                got.length  = o_new_length;
                if (pending_results.size() == 0) begin
                    note_mismatch("unexpected result word (removed value)", '0,
                                  got.removed);
                end else begin
                    want = pending_results.pop_front();
                    if (got.removed !== want.removed)
                        note_mismatch("removed value", want.removed, got.removed);
                    if (got.status !== want.status)
                        note_mismatch("status", iirl_pkg::ITEM_W'(want.status),
                                      iirl_pkg::ITEM_W'(got.status));
                    if (got.length !== want.length)
                        note_mismatch("new length", iirl_pkg::ITEM_W'(want.length),
                                      iirl_pkg::ITEM_W'(got.length));
                end
            end
            if (start && !busy) begin
                pred = apply_word(i_command, i_position, i_item_value);
                pending_results.push_back(word_typed ? word_expect : pred);
            end
        end
    end

    // Watchdog: the slowest correct run is far below this.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d result words still pending.",
                     cycle_count, pending_results.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Idle cycles before a word: mostly none, some short, a few long.
    function automatic int unsigned pick_gap();
        int unsigned r;

        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------------
    // Sender. It is entered just after a rising edge. With no gap, start stays
    // high and only the fields change, so words go back to back. The word is
    // taken at the first edge where busy is low.
    // ------------------------------------------------------------------------
    task automatic send_word(logic [iirl_pkg::CMD_W-1:0] cmd,
                             logic [iirl_pkg::POS_W-1:0] pos,
                             logic [iirl_pkg::ITEM_W-1:0] val, bit typed,
                             t_list_result res);
        int unsigned gap;

        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_command    <= cmd;
        i_position   <= pos;
        i_item_value <= val;
        word_typed   <= typed;
        word_expect  <= res;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // Hold the sender off until every expected result word has come back.
    task automatic wait_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [iirl_pkg::ITEM_W-1:0] pick_value();
        int unsigned r;

        r = $urandom_range(0, 15);
        if (r == 0) return '0;
        if (r == 1) return ALL_ONES;
        return {$urandom(), $urandom()};
    endfunction

    initial begin : stimulus
        bit                         grow;
        int unsigned                phase_left;
        logic [iirl_pkg::CMD_W-1:0] cmd;
        logic [iirl_pkg::POS_W-1:0] pos;

        // Directed table. Rows with a typed result can be read off at once:
        // the empty list, the undefined codes, the full list, indexes past
        // the end. The others lean on the shadow.
        dir_rows = '{
            '{iirl_pkg::CMD_POP, 8'd0, '0, 1, 1'b1, '{'0, iirl_pkg::ST_NIL, 5'd0}},
            '{iirl_pkg::CMD_SHIFT, 8'd255, ALL_ONES, 1, 1'b1,
              '{'0, iirl_pkg::ST_NIL, 5'd0}},
            '{iirl_pkg::CMD_REMOVE, 8'd0, '0, 1, 1'b1, '{'0, iirl_pkg::ST_NIL, 5'd0}},
            '{CMD_UNDEF_6, 8'd0, '0, 1, 1'b1, '{'0, iirl_pkg::ST_NIL, 5'd0}},
            '{CMD_UNDEF_7, 8'd255, ALL_ONES, 1, 1'b1, '{'0, iirl_pkg::ST_NIL, 5'd0}},
            // Insert far past the end is clamped and appends.
            '{iirl_pkg::CMD_INSERT, 8'd255, ALL_ONES, 1, 1'b1,
              '{'0, iirl_pkg::ST_OK, 5'd1}},
            '{iirl_pkg::CMD_UNSHIFT, 8'd0, '0, 1, 1'b1, '{'0, iirl_pkg::ST_OK, 5'd2}},
            '{iirl_pkg::CMD_INSERT, 8'd1, 64'h0123_4567_89ab_cdef, 1, 1'b0, '0},
            '{iirl_pkg::CMD_REMOVE, 8'd3, '0, 1, 1'b1, '{'0, iirl_pkg::ST_NIL, 5'd3}},
            // Fill up to the last free entry.
            '{iirl_pkg::CMD_PUSH, 8'd0, 64'h5555_0000_0000_0000, 13, 1'b0, '0},
            '{iirl_pkg::CMD_INSERT, 8'd0, ALL_ONES, 1, 1'b1,
              '{'0, iirl_pkg::ST_FULL, 5'd16}},
            '{iirl_pkg::CMD_PUSH, 8'd0, ALL_ONES, 1, 1'b1,
              '{'0, iirl_pkg::ST_FULL, 5'd16}},
            '{iirl_pkg::CMD_UNSHIFT, 8'd0, ALL_ONES, 1, 1'b1,
              '{'0, iirl_pkg::ST_FULL, 5'd16}},
            '{iirl_pkg::CMD_REMOVE, 8'd15, '0, 1, 1'b0, '0},
            '{iirl_pkg::CMD_INSERT, 8'd15, 64'haaaa_aaaa_aaaa_aaaa, 1, 1'b0, '0},
            '{iirl_pkg::CMD_REMOVE, 8'd0, '0, 1, 1'b0, '0},
            '{iirl_pkg::CMD_INSERT, 8'd7, 64'h8000_0000_0000_0001, 1, 1'b0, '0},
            '{iirl_pkg::CMD_SHIFT, 8'd0, '0, 1, 1'b0, '0},
            '{iirl_pkg::CMD_POP, 8'd0, '0, 1, 1'b0, '0},
            '{iirl_pkg::CMD_REMOVE, 8'd14, '0, 1, 1'b1,
              '{'0, iirl_pkg::ST_NIL, 5'd14}}
        };

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r]) begin
            for (int unsigned k = 0; k < dir_rows[r].reps; k++) begin
                send_word(dir_rows[r].cmd, dir_rows[r].pos, dir_rows[r].val + k,
                          dir_rows[r].typed, dir_rows[r].res);
            end
        end
        wait_drained();

        // Random part. Growing and shrinking phases alternate so that the
        // length sweeps between empty and full again and again. Positions
        // mostly land near the live range, now and then anywhere.
        grow       = 1'b0;
        phase_left = 0;
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (phase_left == 0) begin
                grow       = ~grow;
                phase_left = $urandom_range(20, 80);
            end
            phase_left--;
            if (n % 150 == 0) no_idle = ($urandom_range(0, 3) == 0);
            if (n % 400 == 399) wait_drained();

            if ($urandom_range(0, 99) < 2) begin
                cmd = $urandom_range(0, 1) ? CMD_UNDEF_6 : CMD_UNDEF_7;
            end else if ($urandom_range(0, 99) < (grow ? 70 : 30)) begin
                case ($urandom_range(0, 2))
                    0:       cmd = iirl_pkg::CMD_INSERT;
                    1:       cmd = iirl_pkg::CMD_PUSH;
                    default: cmd = iirl_pkg::CMD_UNSHIFT;
                endcase
            end else begin
                case ($urandom_range(0, 2))
                    0:       cmd = iirl_pkg::CMD_REMOVE;
                    1:       cmd = iirl_pkg::CMD_POP;
                    default: cmd = iirl_pkg::CMD_SHIFT;
                endcase
            end
            if ($urandom_range(0, 9) == 0) pos = iirl_pkg::POS_W'($urandom_range(0, 255));
            else pos = iirl_pkg::POS_W'($urandom_range(0, DEPTH + 1));

            send_word(cmd, pos, pick_value(), 1'b0, '0);
        end

        // Let the last result words out, then keep the clock running so that any
        // stray strobe is caught.
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        $display("Run covered %0d adding, %0d taking and %0d undefined words;",
                 adds_seen, takes_seen, undef_seen);
        $display("  %0d nil and %0d full results, longest list %0d entries.",
                 nil_seen, full_seen, peak_length);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches, %0d result words never seen.", error_count,
                     pending_results.size());
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
